/* sv/asr_pkg.sv */
// Shared types, constants and the sine table generator of the axis rotation seed replicator.
package asr_pkg;

	// Input beat: one seed voxel index triple.
	typedef struct packed {
		logic [9:0] seed_i;
		logic [9:0] seed_j;
		logic [9:0] seed_k;
	} in_beat_t;

	// Output beat: one rotated voxel index triple.
	typedef struct packed {
		logic [5:0]         rotation_index;
		logic signed [15:0] out_i;
		logic signed [15:0] out_j;
		logic signed [15:0] out_k;
		logic               in_bounds;
		logic               last_of_run;
	} out_beat_t;

	// Configuration register contents.
	typedef struct packed {
		logic [47:0] axis_vector;
		logic [47:0] center_point;
		logic [47:0] grid_origin;
		logic [47:0] grid_span;
		logic [47:0] grid_inverse_span;
		logic [47:0] grid_dims;
		logic [6:0]  rotation_count;
		logic [15:0] phase_step;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rom_en;
		logic mat_en;
		logic prod_en;
		logic sum_en;
		logic scale_en;
		logic out_load;
		logic next;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic last;
	} stat_t;

	// Register indexes.
	localparam logic [2:0] REG_AXIS   = 3'd0;
	localparam logic [2:0] REG_CENTER = 3'd1;
	localparam logic [2:0] REG_ORIGIN = 3'd2;
	localparam logic [2:0] REG_SPAN   = 3'd3;
	localparam logic [2:0] REG_INV    = 3'd4;
	localparam logic [2:0] REG_DIMS   = 3'd5;
	localparam logic [2:0] REG_COUNT  = 3'd6;
	localparam logic [2:0] REG_STEP   = 3'd7;

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Sine of a phase given in 1/2^32 of a turn, as signed Q1.14.
	// A fixed Q30 Taylor series on the reduced quarter wave, evaluated at elaboration.
	function automatic logic signed [15:0] sine_q14(input logic [63:0] p);
		logic [1:0]  q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		q = p[31:30];
		r = {34'd0, p[29:0]};
		if (q[0]) begin
			r = Q30_ONE - r;
		end
		x  = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		v  = (s + 64'd32768) >> 16;
		if (v > 64'd16384) begin
			v = 64'd16384;
		end
		return q[1] ? -16'(v) : 16'(v);
	endfunction

endpackage

/* sv/asr_regs.sv */
// Configuration register file with its APB-style access port.
module asr_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	output asr_pkg::cfg_t      cfg
);
	import asr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[5:3];
	assign cfg    = cfg_q;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{rotation_count: 7'd1, default: '0};
		end else if (wr_en) begin
			case (idx)
				REG_AXIS:   cfg_q.axis_vector       <= pwdata[47:0];
				REG_CENTER: cfg_q.center_point      <= pwdata[47:0];
				REG_ORIGIN: cfg_q.grid_origin       <= pwdata[47:0];
				REG_SPAN:   cfg_q.grid_span         <= pwdata[47:0];
				REG_INV:    cfg_q.grid_inverse_span <= pwdata[47:0];
				REG_DIMS:   cfg_q.grid_dims         <= pwdata[47:0];
				REG_COUNT:  cfg_q.rotation_count    <= pwdata[6:0];
				REG_STEP:   cfg_q.phase_step        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (idx)
			REG_AXIS:   prdata = {16'd0, cfg_q.axis_vector};
			REG_CENTER: prdata = {16'd0, cfg_q.center_point};
			REG_ORIGIN: prdata = {16'd0, cfg_q.grid_origin};
			REG_SPAN:   prdata = {16'd0, cfg_q.grid_span};
			REG_INV:    prdata = {16'd0, cfg_q.grid_inverse_span};
			REG_DIMS:   prdata = {16'd0, cfg_q.grid_dims};
			REG_COUNT:  prdata = {57'd0, cfg_q.rotation_count};
			REG_STEP:   prdata = {48'd0, cfg_q.phase_step};
			default:    prdata = '0;
		endcase
	end
endmodule

/* sv/asr_ctrl.sv */
// Sequencer that steps the datapath through each rotation of a seed.
module asr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  asr_pkg::stat_t stat,
	output asr_pkg::cmd_t  cmd
);
	import asr_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROM   = 3'd1;
	localparam logic [2:0] ST_MAT   = 3'd2;
	localparam logic [2:0] ST_PROD  = 3'd3;
	localparam logic [2:0] ST_SUM   = 3'd4;
	localparam logic [2:0] ST_SCALE = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ROM;
				end
			end
			ST_ROM: begin
				cmd.rom_en = 1'b1;
				state_d    = ST_MAT;
			end
			ST_MAT: begin
				cmd.mat_en = 1'b1;
				state_d    = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod_en = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale_en = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next = 1'b1;
						state_d  = ST_ROM;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* sv/asr_dp.sv */
// Datapath: seed offset, sine lookup, rotation matrix, products and voxel mapping.
module asr_dp #(
	parameter int MAX_ROTATIONS    = 64,
	parameter int INDEX_BITS       = 10,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  asr_pkg::cfg_t     cfg,
	input  asr_pkg::in_beat_t in_data,
	input  asr_pkg::cmd_t     cmd,
	output asr_pkg::stat_t    stat,
	output logic              out_valid,
	input  logic              out_stall,
	output asr_pkg::out_beat_t out_data
);
	import asr_pkg::*;

	localparam int TW = $clog2(SINE_TABLE_DEPTH);
	localparam logic [9:0] IMASK = 10'((64'd1 << INDEX_BITS) - 64'd1);
	localparam logic [6:0] MAXC  = 7'(MAX_ROTATIONS);

	// Sine table, built at elaboration.
	logic signed [15:0] sine_tab [SINE_TABLE_DEPTH];
	for (genvar m = 0; m < SINE_TABLE_DEPTH; m++) begin : g_tab
		localparam logic [63:0] PM = (64'(m) << 32) / SINE_TABLE_DEPTH;
		assign sine_tab[m] = sine_q14(PM);
	end

	// Field views of the configuration.
	logic signed [15:0] ax [3];
	logic signed [15:0] ctr [3];
	logic signed [15:0] org [3];
	logic [15:0]        spn [3];
	logic [15:0]        inv [3];
	logic [15:0]        dim [3];
	logic [9:0]         seed [3];
	for (genvar a = 0; a < 3; a++) begin : g_fld
		assign ax[a]  = cfg.axis_vector[16*a +: 16];
		assign ctr[a] = cfg.center_point[16*a +: 16];
		assign org[a] = cfg.grid_origin[16*a +: 16];
		assign spn[a] = cfg.grid_span[16*a +: 16];
		assign inv[a] = cfg.grid_inverse_span[16*a +: 16];
		assign dim[a] = cfg.grid_dims[16*a +: 16];
	end
	assign seed[0] = in_data.seed_i & IMASK;
	assign seed[1] = in_data.seed_j & IMASK;
	assign seed[2] = in_data.seed_k & IMASK;

	// Angle count, clamped to one through the maximum.
	logic [6:0] count;
	always_comb begin
		if (cfg.rotation_count == 7'd0) begin
			count = 7'd1;
		end else if (cfg.rotation_count > MAXC) begin
			count = MAXC;
		end else begin
			count = cfg.rotation_count;
		end
	end

	logic [5:0]  n_q;
	logic [15:0] phase_q;
	assign stat.last = ({1'b0, n_q} == count - 7'd1);

	// Seed offset and axis pair products, captured when a seed beat is taken.
	logic signed [15:0] off_q [3];
	logic signed [31:0] pp_q [3][3];
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [27:0] w;
				w = 28'(org[a]) + 28'($signed({1'b0, seed[a]}) * $signed({1'b0, spn[a]}))
					- 28'(ctr[a]);
				off_q[a] <= (w > 28'sd32767) ? 16'sh7fff :
					((w < -28'sd32768) ? 16'sh8000 : w[15:0]);
			end
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					pp_q[r][k] <= ax[r] * ax[k];
				end
			end
		end
	end

	// Angle number and phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			phase_q <= '0;
		end else if (cmd.load) begin
			n_q     <= '0;
			phase_q <= '0;
		end else if (cmd.next) begin
			n_q     <= n_q + 6'd1;
			phase_q <= phase_q + cfg.phase_step;
		end
	end

	// Stage one: sine and cosine lookup.
	logic [15:0]        cphase;
	logic [31:0]        sprod;
	logic [31:0]        cprod;
	logic signed [15:0] s_s1;
	logic signed [15:0] c_s1;
	assign cphase = phase_q + 16'd16384;
	assign sprod  = 32'(phase_q) * 32'(SINE_TABLE_DEPTH);
	assign cprod  = 32'(cphase) * 32'(SINE_TABLE_DEPTH);
	always_ff @(posedge clk) begin
		if (cmd.rom_en) begin
			s_s1 <= sine_tab[TW'(sprod >> 16)];
			c_s1 <= sine_tab[TW'(cprod >> 16)];
		end
	end

	// Stage two: matrix entries in Q42.
	logic signed [16:0] t_val;
	logic signed [47:0] cq;
	logic signed [47:0] sterm [3];
	logic signed [47:0] m_s2 [3][3];
	assign t_val = 17'sd16384 - 17'(c_s1);
	assign cq    = 48'(c_s1) <<< 28;
	for (genvar a = 0; a < 3; a++) begin : g_st
		assign sterm[a] = 48'(ax[a] * s_s1) <<< 14;
	end
	always_ff @(posedge clk) begin
		if (cmd.mat_en) begin
			m_s2[0][0] <= 48'(pp_q[0][0] * t_val) + cq;
			m_s2[0][1] <= 48'(pp_q[0][1] * t_val) - sterm[2];
			m_s2[0][2] <= 48'(pp_q[0][2] * t_val) + sterm[1];
			m_s2[1][0] <= 48'(pp_q[1][0] * t_val) + sterm[2];
			m_s2[1][1] <= 48'(pp_q[1][1] * t_val) + cq;
			m_s2[1][2] <= 48'(pp_q[1][2] * t_val) - sterm[0];
			m_s2[2][0] <= 48'(pp_q[2][0] * t_val) - sterm[1];
			m_s2[2][1] <= 48'(pp_q[2][1] * t_val) + sterm[0];
			m_s2[2][2] <= 48'(pp_q[2][2] * t_val) + cq;
		end
	end

	// Stage three: round entries to Q14 and multiply by the offset.
	logic signed [35:0] p_s3 [3][3];
	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					logic signed [47:0] rm;
					rm = (m_s2[r][k] + 48'sd134217728) >>> 28;
					p_s3[r][k] <= $signed(rm[19:0]) * off_q[k];
				end
			end
		end
	end

	// Stage four: row sums, round to Q8.8, shift back to grid coordinates.
	logic signed [25:0] w_s4 [3];
	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			for (int r = 0; r < 3; r++) begin
				logic signed [37:0] acc;
				logic signed [37:0] u;
				acc = 38'(p_s3[r][0]) + 38'(p_s3[r][1]) + 38'(p_s3[r][2]);
				u   = (acc + 38'sd8192) >>> 14;
				w_s4[r] <= 26'(u) + 26'(ctr[r]) - 26'(org[r]);
			end
		end
	end

	// Stage five: scale by the inverse spacing and add one half.
	logic signed [43:0] f_s5 [3];
	always_ff @(posedge clk) begin
		if (cmd.scale_en) begin
			for (int r = 0; r < 3; r++) begin
				f_s5[r] <= 44'(w_s4[r] * $signed({1'b0, inv[r]})) + 44'sd32768;
			end
		end
	end

	// Truncate toward zero, bounds check and saturation.
	logic signed [27:0] v [3];
	logic signed [15:0] vs [3];
	logic               inb;
	always_comb begin
		inb = 1'b1;
		for (int r = 0; r < 3; r++) begin
			v[r] = 28'((f_s5[r] + (f_s5[r][43] ? 44'sd65535 : 44'sd0)) >>> 16);
			if (v[r][27] || (v[r] >= $signed({12'd0, dim[r]}))) begin
				inb = 1'b0;
			end
			vs[r] = (v[r] > 28'sd32767) ? 16'sh7fff :
				((v[r] < -28'sd32768) ? 16'sh8000 : v[r][15:0]);
		end
	end

	// Output register.
	logic      out_valid_q;
	out_beat_t out_data_q;
	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q.rotation_index <= n_q;
			out_data_q.out_i          <= vs[0];
			out_data_q.out_j          <= vs[1];
			out_data_q.out_k          <= vs[2];
			out_data_q.in_bounds      <= inb;
			out_data_q.last_of_run    <= stat.last;
		end
	end
endmodule

/* sv/axis_rotation_seed_replicator.sv */
// Top level: register port, sequencer and datapath of the axis rotation seed replicator.
// Each seed beat yields one result beat per angle, rotation_count of them clamped to one
// through MAX_ROTATIONS. Each angle is walked by the sequencer through the five-stage
// datapath from sine lookup to scaling and is then loaded into the output register, where
// a result may wait on a stalled output; a new seed is taken once the last result is in
// the output register.
// Reset is asynchronous and active low; it clears control state and restores the registers.
module axis_rotation_seed_replicator #(
	parameter int MAX_ROTATIONS    = 64,
	parameter int INDEX_BITS       = 10,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  asr_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output asr_pkg::out_beat_t  out_data
);
	import asr_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	asr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	asr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	asr_dp #(
		.MAX_ROTATIONS    (MAX_ROTATIONS),
		.INDEX_BITS       (INDEX_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// A stalled result beat stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	// A seed beat starts a run, so the input side is busy on the next cycle.
	a_busy_after_seed: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not held off after a seed beat");

	// No new seed is taken while a run still has results to give.
	a_no_seed_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_of_run |-> in_stall)
		else $error("seed taken in the middle of a run");
`endif
endmodule
